/* design/slcfr_pkg.sv */
// Shared types, codes and the CRC-16/MODBUS byte update for the frame receiver.
package slcfr_pkg;

    localparam logic [15:0] CRC_INIT      = 16'hFFFF;
    localparam logic [15:0] CRC_POLY      = 16'hA001;
    localparam logic [15:0] SYNC_RESET    = 16'hAA55;
    localparam logic [15:0] MAX_LEN_RESET = 16'd256;
    localparam logic [15:0] MIN_LEN       = 16'd2;
    localparam logic [15:0] CRC_BYTES     = 16'd2;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_SYNC0   = 3'd1,
        PH_SYNC1   = 3'd2,
        PH_LEN0    = 3'd3,
        PH_PAYLOAD = 3'd4
    } t_phase;

    typedef enum logic [1:0] {
        KIND_DATA   = 2'd0,
        KIND_GOOD   = 2'd1,
        KIND_BAD    = 2'd2,
        KIND_LENERR = 2'd3
    } t_kind;

    typedef enum logic {
        CFG_SYNC_PAT = 1'b0,
        CFG_MAX_LEN  = 1'b1
    } t_cfg_index;

    typedef struct packed {
        logic [15:0] sync_pat;
        logic [15:0] max_len;
        logic [15:0] seed_lo;
    } t_cfg;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  data_byte;
        logic [15:0] arg_length;
    } t_result;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

/* design/sync_length_crc_frame_receiver.sv */
// Top level of the sync / length / CRC-16 frame receiver.
//
// Input channel: one received byte per transfer on i_rx_byte, with i_rx_valid
// and o_rx_stall. Output channel: zero or one result per byte on o_kind,
// o_data_byte and o_arg_length, with o_res_valid and i_res_stall. A payload
// byte comes out as kind 0; a frame end reports a good or bad CRC with the
// payload length; a length field out of range reports a length error.
// Configuration: i_cfg_we writes i_cfg_wdata to the sync word (index 0) or
// the maximum length field (index 1); write only while no frame is in flight.
// A byte transfers into the input register; its result then passes through the
// result register to the output. Throughput: one byte per cycle unless stalled;
// the byte-wide CRC update and the state machine sit in one stage.
// Reset (synchronous, active low) empties both registers, returns the parser
// to sync hunting and restores sync word 0xAA55 and maximum length 256.
// When the receiver stalls, the result is held; an empty input register still
// takes one byte, and o_rx_stall then stays high until the result moves.
module sync_length_crc_frame_receiver import slcfr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_rx_valid,
    output logic        o_rx_stall,
    input  logic [7:0]  i_rx_byte,
    output logic        o_res_valid,
    input  logic        i_res_stall,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_data_byte,
    output logic [15:0] o_arg_length,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_wdata
);

    t_cfg    w_cfg;
    t_result w_res;
    logic    w_res_valid;
    logic    w_out_free;

    slcfr_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (t_cfg_index'(i_cfg_index)),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (w_cfg)
    );

    slcfr_parse u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rx_valid  (i_rx_valid),
        .o_rx_stall  (o_rx_stall),
        .i_rx_byte   (i_rx_byte),
        .i_cfg       (w_cfg),
        .i_out_free  (w_out_free),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    slcfr_outreg u_outreg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_res_valid  (w_res_valid),
        .i_res        (w_res),
        .o_free       (w_out_free),
        .o_res_valid  (o_res_valid),
        .i_res_stall  (i_res_stall),
        .o_kind       (o_kind),
        .o_data_byte  (o_data_byte),
        .o_arg_length (o_arg_length)
    );

endmodule

/* design/slcfr_cfg.sv */
// Configuration registers and the CRC seed of the low sync byte.
module slcfr_cfg import slcfr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  t_cfg_index  i_cfg_index,
    input  logic [15:0] i_cfg_wdata,
    output t_cfg        o_cfg
);

    logic [15:0] r_sync_pat;
    logic [15:0] r_max_len;
    logic [15:0] r_seed_lo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_pat <= SYNC_RESET;
            r_max_len  <= MAX_LEN_RESET;
            r_seed_lo  <= crc_byte(CRC_INIT, SYNC_RESET[7:0]);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SYNC_PAT: begin
                    r_sync_pat <= i_cfg_wdata;
                    r_seed_lo  <= crc_byte(CRC_INIT, i_cfg_wdata[7:0]);
                end
                CFG_MAX_LEN: begin
                    r_max_len <= i_cfg_wdata;
                end
                default: begin
                    r_max_len <= r_max_len;
                end
            endcase
        end
    end

    assign o_cfg.sync_pat = r_sync_pat;
    assign o_cfg.max_len  = r_max_len;
    assign o_cfg.seed_lo  = r_seed_lo;

endmodule

/* design/slcfr_parse.sv */
// Input register and the frame state machine with the running CRC.
module slcfr_parse import slcfr_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_rx_valid,
    output logic       o_rx_stall,
    input  logic [7:0] i_rx_byte,
    input  t_cfg       i_cfg,
    input  logic       i_out_free,
    output logic       o_res_valid,
    output t_result    o_res
);

    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    t_phase      r_phase;
    t_phase      n_phase;
    logic [15:0] r_crc;
    logic [15:0] n_crc;
    logic [7:0]  r_len_lo;
    logic [7:0]  n_len_lo;
    logic [15:0] r_body;
    logic [15:0] n_body;
    logic [15:0] r_count;
    logic [15:0] n_count;
    logic [7:0]  r_crc_lo;
    logic [7:0]  n_crc_lo;
    logic        w_go;
    logic        w_accept;
    logic [15:0] w_len;
    logic [15:0] w_crc_upd;

    assign w_go       = r_in_valid && i_out_free;
    assign o_rx_stall = r_in_valid && !w_go;
    assign w_accept   = i_rx_valid && !o_rx_stall;
    assign w_len      = {r_in_byte, r_len_lo};
    assign w_crc_upd  = crc_byte(r_crc, r_in_byte);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_go) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_byte <= i_rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_crc    <= CRC_INIT;
            r_len_lo <= '0;
            r_body   <= '0;
            r_count  <= '0;
            r_crc_lo <= '0;
        end else begin
            r_phase  <= n_phase;
            r_crc    <= n_crc;
            r_len_lo <= n_len_lo;
            r_body   <= n_body;
            r_count  <= n_count;
            r_crc_lo <= n_crc_lo;
        end
    end

    always_comb begin
        n_phase     = r_phase;
        n_crc       = r_crc;
        n_len_lo    = r_len_lo;
        n_body      = r_body;
        n_count     = r_count;
        n_crc_lo    = r_crc_lo;
        o_res_valid = 1'b0;
        o_res       = '0;
        if (w_go) begin
            unique case (r_phase)
                PH_IDLE: begin
                    if (r_in_byte == i_cfg.sync_pat[7:0]) begin
                        n_phase = PH_SYNC0;
                    end
                end
                PH_SYNC0: begin
                    if (r_in_byte == i_cfg.sync_pat[15:8]) begin
                        n_crc   = crc_byte(i_cfg.seed_lo, r_in_byte);
                        n_phase = PH_SYNC1;
                    end else begin
                        n_phase = PH_IDLE;
                    end
                end
                PH_SYNC1: begin
                    n_len_lo = r_in_byte;
                    n_crc    = w_crc_upd;
                    n_phase  = PH_LEN0;
                end
                PH_LEN0: begin
                    if (w_len > i_cfg.max_len || w_len < MIN_LEN) begin
                        n_phase     = PH_IDLE;
                        o_res_valid = 1'b1;
                        o_res.kind  = KIND_LENERR;
                    end else begin
                        n_count = '0;
                        n_crc   = w_crc_upd;
                        n_body  = w_len - CRC_BYTES;
                        n_phase = PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD: begin
                    n_count = r_count + 16'd1;
                    priority if (r_count < r_body) begin
                        n_crc           = w_crc_upd;
                        o_res_valid     = 1'b1;
                        o_res.kind      = KIND_DATA;
                        o_res.data_byte = r_in_byte;
                    end else if (r_count == r_body) begin
                        n_crc_lo = r_in_byte;
                    end else begin
                        n_phase          = PH_IDLE;
                        o_res_valid      = 1'b1;
                        o_res.kind       = ({r_in_byte, r_crc_lo} == r_crc) ? KIND_GOOD
                                                                            : KIND_BAD;
                        o_res.arg_length = r_body;
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end
    end

endmodule

/* design/slcfr_outreg.sv */
// Result register that holds a transfer while the receiver stalls.
module slcfr_outreg import slcfr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_res_valid,
    input  t_result     i_res,
    output logic        o_free,
    output logic        o_res_valid,
    input  logic        i_res_stall,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_data_byte,
    output logic [15:0] o_arg_length
);

    logic    r_valid;
    t_result r_res;
    logic    w_load;

    assign o_free = !r_valid || !i_res_stall;
    assign w_load = i_res_valid && o_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_res <= i_res;
        end
    end

    assign o_res_valid  = r_valid;
    assign o_kind       = r_res.kind;
    assign o_data_byte  = r_res.data_byte;
    assign o_arg_length = r_res.arg_length;

endmodule

/* design/slcfr_checker.sv */
// Port-level checks on the frame receiver, bound to the top level.
module slcfr_checker import slcfr_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_rx_stall,
    input logic        o_res_valid,
    input logic        i_res_stall,
    input logic [1:0]  o_kind,
    input logic [7:0]  o_data_byte,
    input logic [15:0] o_arg_length
);

    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && i_res_stall |=> o_res_valid && $stable(o_kind)
            && $stable(o_data_byte) && $stable(o_arg_length))
        else $error("stalled result changed");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rx_stall |-> o_res_valid && i_res_stall)
        else $error("input stalled without a stalled result");

    a_data_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_kind != KIND_DATA |-> o_data_byte == 8'd0)
        else $error("data byte not zero on a status result");

    a_len_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && (o_kind == KIND_DATA || o_kind == KIND_LENERR)
            |-> o_arg_length == 16'd0)
        else $error("length not zero on a data or length error result");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_res_valid)
        else $error("result valid after reset");

endmodule

bind sync_length_crc_frame_receiver slcfr_checker u_slcfr_checker (.*);

/* tb/sv/sync_length_crc_frame_receiver_tb.sv */
// Self-checking testbench for the sync / length / CRC-16 frame receiver.
module sync_length_crc_frame_receiver_tb;
    import slcfr_pkg::*;

    localparam int KEEP_ALL = 1 << 30;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_rx_valid;
    logic        o_rx_stall;
    logic [7:0]  i_rx_byte;
    logic        o_res_valid;
    logic        i_res_stall;
    logic [1:0]  o_kind;
    logic [7:0]  o_data_byte;
    logic [15:0] o_arg_length;
    logic        i_cfg_we;
    logic        i_cfg_index;
    logic [15:0] i_cfg_wdata;

    t_phase      rx_state;
    logic [15:0] cfg_sync;
    logic [15:0] cfg_max;
    logic [15:0] frame_len;
    logic [15:0] body_idx;
    logic [15:0] crc_acc;
    logic [7:0]  crc_lo;
    t_result     expected_results[$];

    bit rx_steady;
    bit res_steady;
    int fail_count;
    int rx_transfers;
    int cfg_writes;
    int n_data;
    int n_good;
    int n_bad;
    int n_lenerr;

    sync_length_crc_frame_receiver dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_rx_valid   (i_rx_valid),
        .o_rx_stall   (o_rx_stall),
        .i_rx_byte    (i_rx_byte),
        .o_res_valid  (o_res_valid),
        .i_res_stall  (i_res_stall),
        .o_kind       (o_kind),
        .o_data_byte  (o_data_byte),
        .o_arg_length (o_arg_length),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_wdata  (i_cfg_wdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [15:0] modbus_crc_step(input logic [15:0] acc,
                                                    input logic [7:0] octet);
        logic [15:0] r;
        logic        fb;
        r = acc;
        for (int k = 0; k < 8; k++) begin
            fb = r[0] ^ octet[k];
            r  = {1'b0, r[15:1]} ^ (fb ? CRC_POLY : 16'h0000);
        end
        return r;
    endfunction

    function automatic int pick_gap(input bit steady);
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 70) begin
            return 0;
        end
        if (r < 95) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    function automatic void push_result(input t_kind k, input logic [7:0] d,
                                        input logic [15:0] l);
        t_result r;
        r.kind       = k;
        r.data_byte  = d;
        r.arg_length = l;
        expected_results.push_back(r);
    endfunction

    function automatic void predict_rx(input logic [7:0] b);
        logic [15:0] body;
        body = frame_len - CRC_BYTES;
        case (rx_state)
            PH_IDLE: begin
                if (b == cfg_sync[7:0]) begin
                    rx_state = PH_SYNC0;
                end
            end
            PH_SYNC0: begin
                if (b == cfg_sync[15:8]) begin
                    crc_acc  = modbus_crc_step(modbus_crc_step(CRC_INIT, cfg_sync[7:0]),
                                               cfg_sync[15:8]);
                    rx_state = PH_SYNC1;
                end else begin
                    rx_state = PH_IDLE;
                end
            end
            PH_SYNC1: begin
                frame_len = {8'h00, b};
                rx_state  = PH_LEN0;
            end
            PH_LEN0: begin
                frame_len[15:8] = b;
                if (frame_len > cfg_max || frame_len < MIN_LEN) begin
                    push_result(KIND_LENERR, 8'h00, 16'h0000);
                    rx_state = PH_IDLE;
                end else begin
                    body_idx = 16'h0000;
                    crc_acc  = modbus_crc_step(modbus_crc_step(crc_acc, frame_len[7:0]),
                                               frame_len[15:8]);
                    rx_state = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                if (body_idx < body) begin
                    crc_acc = modbus_crc_step(crc_acc, b);
                    push_result(KIND_DATA, b, 16'h0000);
                end else if (body_idx == body) begin
                    crc_lo = b;
                end else begin
                    push_result(({b, crc_lo} == crc_acc) ? KIND_GOOD : KIND_BAD,
                                8'h00, body);
                    rx_state = PH_IDLE;
                end
                body_idx = body_idx + 16'd1;
            end
            default: begin
                rx_state = PH_IDLE;
            end
        endcase
    endfunction

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = pick_gap(rx_steady);
        @(negedge i_clk);
        if (gap > 0) begin
            i_rx_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_rx_valid <= 1'b1;
        i_rx_byte  <= b;
        @(posedge i_clk);
        while (o_rx_stall) @(posedge i_clk);
        predict_rx(b);
        rx_transfers++;
    endtask

    task automatic send_frame(input logic [15:0] len_field, input bit bad_crc,
                              input bit extremes, input int keep);
        logic [7:0]  seq[$];
        logic [15:0] crc;
        seq = {cfg_sync[7:0], cfg_sync[15:8], len_field[7:0], len_field[15:8]};
        if (len_field >= MIN_LEN && len_field <= cfg_max) begin
            for (int k = 0; k < int'(len_field - CRC_BYTES); k++) begin
                seq.push_back(extremes ? ((k % 2) ? 8'hFF : 8'h00) : 8'($urandom));
            end
            crc = CRC_INIT;
            foreach (seq[k]) crc = modbus_crc_step(crc, seq[k]);
            if (bad_crc) begin
                crc ^= 16'($urandom_range(1, 16'hFFFF));
            end
            seq.push_back(crc[7:0]);
            seq.push_back(crc[15:8]);
        end
        foreach (seq[k]) begin
            if (k < keep) begin
                send_byte(seq[k]);
            end
        end
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        i_rx_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_index idx, input logic [15:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_SYNC_PAT) begin
            cfg_sync = value;
        end else begin
            cfg_max = value;
        end
        cfg_writes++;
    endtask

    task automatic apply_setting(input logic [15:0] sync_val, input logic [15:0] max_len);
        // flush any partial frame so the parser is hunting before the write
        while (rx_state != PH_IDLE) send_byte(8'($urandom));
        drain_results();
        write_reg(CFG_SYNC_PAT, sync_val);
        write_reg(CFG_MAX_LEN, max_len);
    endtask

    task automatic run_traffic(input int quota, input bit noisy);
        int start;
        int pick;
        int body;
        int top;
        start = rx_transfers;
        while (rx_transfers - start < quota) begin
            if ($urandom_range(0, 15) == 0) begin
                rx_steady  = ($urandom_range(0, 3) == 0);
                res_steady = ($urandom_range(0, 3) == 0);
            end
            pick = $urandom_range(0, 99);
            if (noisy && pick < 8) begin
                repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
            end else if (pick < 20) begin
                if (cfg_max == 16'hFFFF || $urandom_range(0, 2) == 0) begin
                    send_frame(16'($urandom_range(0, 1)), 1'b0, 1'b0, KEEP_ALL);
                end else if ($urandom_range(0, 1) == 0) begin
                    send_frame(cfg_max + 16'd1, 1'b0, 1'b0, KEEP_ALL);
                end else begin
                    send_frame(16'($urandom_range(cfg_max + 1, 16'hFFFF)), 1'b0, 1'b0,
                               KEEP_ALL);
                end
            end else begin
                top = cfg_max - CRC_BYTES;
                if (top > 60) begin
                    top = 60;
                end
                if (top > 16 && $urandom_range(0, 9) != 0) begin
                    top = 16;
                end
                body = ($urandom_range(0, 7) == 0) ? top : $urandom_range(0, top);
                send_frame(16'(body + 2), pick < 40, 1'b0,
                           (noisy && pick >= 94) ? $urandom_range(1, body + 5) : KEEP_ALL);
            end
        end
    endtask

    task automatic test_sync_hunt();
        send_byte(SYNC_RESET[7:0]);
        send_byte(SYNC_RESET[7:0]);
        send_byte(SYNC_RESET[15:8]);
        send_byte(8'h02);
        send_byte(8'h00);
    endtask

    task automatic test_empty_frame();
        send_frame(MIN_LEN, 1'b0, 1'b0, KEEP_ALL);
    endtask

    task automatic test_length_reject();
        send_frame(16'h0000, 1'b0, 1'b0, KEEP_ALL);
        send_frame(16'hFFFF, 1'b0, 1'b0, KEEP_ALL);
    endtask

    task automatic test_payload_extremes();
        send_frame(16'd4, 1'b1, 1'b1, KEEP_ALL);
    endtask

    task automatic test_setting_sweep();
        run_traffic(260, 1'b1);
        apply_setting(16'h0000, MIN_LEN);
        run_traffic(260, 1'b1);
        apply_setting(16'hFFFF, 16'hFFFF);
        run_traffic(260, 1'b0);
        apply_setting(16'($urandom), 16'($urandom_range(3, 64)));
        run_traffic(260, 1'b1);
        apply_setting(16'($urandom), 16'($urandom_range(65, 300)));
        run_traffic(260, 1'b1);
        apply_setting(SYNC_RESET, MAX_LEN_RESET);
        run_traffic(260, 1'b1);
    endtask

    initial begin : res_stall_gen
        int hold;
        int busy;
        i_res_stall = 1'b0;
        forever begin
            hold = pick_gap(res_steady);
            busy = $urandom_range(1, 6);
            if (hold > 0) begin
                @(negedge i_clk);
                i_res_stall <= 1'b1;
                repeat (hold - 1) @(negedge i_clk);
            end
            @(negedge i_clk);
            i_res_stall <= 1'b0;
            repeat (busy - 1) @(negedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_res_valid && !i_res_stall) begin
            case (t_kind'(o_kind))
                KIND_DATA:   n_data++;
                KIND_GOOD:   n_good++;
                KIND_BAD:    n_bad++;
                KIND_LENERR: n_lenerr++;
                default:     ;
            endcase
            if (expected_results.size() == 0) begin
                $error("unexpected result: kind %0d data_byte %0d arg_length %0d",
                       o_kind, o_data_byte, o_arg_length);
                fail_count++;
            end else begin
                want = expected_results.pop_front();
                if (o_kind !== want.kind) begin
                    $error("kind: expected %0d, got %0d", want.kind, o_kind);
                    fail_count++;
                end
                if (o_data_byte !== want.data_byte) begin
                    $error("data_byte: expected %0d, got %0d", want.data_byte, o_data_byte);
                    fail_count++;
                end
                if (o_arg_length !== want.arg_length) begin
                    $error("arg_length: expected %0d, got %0d", want.arg_length, o_arg_length);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        i_rst_n     = 1'b0;
        i_rx_valid  = 1'b0;
        i_rx_byte   = 8'h00;
        i_cfg_we    = 1'b0;
        i_cfg_index = CFG_SYNC_PAT;
        i_cfg_wdata = 16'h0000;
        rx_steady   = 1'b0;
        res_steady  = 1'b0;
        cfg_sync    = SYNC_RESET;
        cfg_max     = MAX_LEN_RESET;
        rx_state    = PH_IDLE;
        frame_len   = 16'h0000;
        body_idx    = 16'h0000;
        crc_acc     = CRC_INIT;
        crc_lo      = 8'h00;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_sync_hunt();
        test_empty_frame();
        test_length_reject();
        test_payload_extremes();
        test_setting_sweep();
        drain_results();

        $display("covered %0d byte transfers and %0d register writes over six settings",
                 rx_transfers, cfg_writes);
        $display("saw %0d payload bytes, %0d good frames, %0d bad-CRC frames, %0d length rejects",
                 n_data, n_good, n_bad, n_lenerr);
        if (fail_count == 0) begin
            $display("sync_length_crc_frame_receiver: match");
        end else begin
            $display("sync_length_crc_frame_receiver: mismatch");
        end
        $finish;
    end

    initial begin
        #8_000_000;
        $display("sync_length_crc_frame_receiver: mismatch");
        $finish;
    end

endmodule
